// ----- src/zcrs_pkg.sv -----
// package: shared types and register indexes for the zoned color ramp shader
`timescale 1ns / 1ps
package zcrs_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int COLOR_W   = 24;
  localparam int GAIN_W    = 10;

  localparam logic [CFG_IDX_W-1:0] REG_INNER_EDGE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MID_EDGE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_COLOR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MID_COLOR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_COLOR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OPACITY_GAIN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SMOKE_MIX    = 3'd6;

  typedef enum logic [1:0] {
    ZONE_INNER,
    ZONE_MID,
    ZONE_OUTER
  } zone_t;

endpackage

// ----- src/zcrs_if.sv -----
// interfaces: input and result channels of the shader
`timescale 1ns / 1ps
interface zcrs_in_if #(parameter int RW = 17);
  logic          valid;
  logic          ready;
  logic [RW-1:0] distance_ratio;
  logic [RW-1:0] life_ratio;
  modport source (output valid, output distance_ratio, output life_ratio, input ready);
  modport sink (input valid, input distance_ratio, input life_ratio, output ready);
endinterface

interface zcrs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  modport source (output valid, output red, output green, output blue, output alpha,
                  input ready);
  modport sink (input valid, input red, input green, input blue, input alpha,
                output ready);
endinterface

// ----- src/zcrs_div.sv -----
// pipelined restoring divider, one quotient bit per stage, with sideband
`timescale 1ns / 1ps
module zcrs_div #(
  parameter int W  = 17,
  parameter int QB = 16,
  parameter int SW = 19
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [W-1:0]  num,
  input  logic [W-1:0]  den,
  input  logic          sat,
  input  logic [SW-1:0] side,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [QB-1:0] quot,
  output logic          out_sat,
  output logic [SW-1:0] out_side
);

  logic [W-1:0]  rem_r  [0:QB];
  logic [W-1:0]  den_r  [0:QB];
  logic [QB-1:0] q_r    [0:QB];
  logic          sat_r  [0:QB];
  logic [SW-1:0] side_r [0:QB];
  logic [QB:0]   v_r;
  logic [QB+1:0] en;
  logic [W:0]    r2     [1:QB];
  logic          ge     [1:QB];
  logic [W-1:0]  rem_nxt[1:QB];

  always_comb begin
    en[QB+1] = out_ready;
    for (int i = QB; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  always_comb begin
    for (int i = 1; i <= QB; i++) begin
      r2[i]      = {rem_r[i-1], 1'b0};
      ge[i]      = r2[i] >= {1'b0, den_r[i-1]};
      rem_nxt[i] = ge[i] ? W'(r2[i] - {1'b0, den_r[i-1]}) : W'(r2[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int i = 1; i <= QB; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_r[0]  <= sat ? '0 : num;
      den_r[0]  <= den;
      q_r[0]    <= '0;
      sat_r[0]  <= sat;
      side_r[0] <= side;
    end
    for (int i = 1; i <= QB; i++) begin
      if (en[i]) begin
        rem_r[i]  <= rem_nxt[i];
        den_r[i]  <= den_r[i-1];
        q_r[i]    <= {q_r[i-1][QB-2:0], ge[i]};
        sat_r[i]  <= sat_r[i-1];
        side_r[i] <= side_r[i-1];
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[QB];
  assign quot      = q_r[QB];
  assign out_sat   = sat_r[QB];
  assign out_side  = side_r[QB];

endmodule

// ----- src/zoned_color_ramp_shader.sv -----
// top level: zoned color ramp shader pipeline
//
//  channel   dir  handshake          payload
//  in_chan   in   valid / ready      distance_ratio, life_ratio
//  out_chan  out  valid / ready      red, green, blue, alpha
//  cfg_*     in   cfg_we only        cfg_index, cfg_data
//
//  one transaction per cycle unless out_chan stalls; the path runs through the
//  one-bit-per-stage zone divider followed by eight shading stages
//  synchronous active-low reset clears all valid bits and loads register defaults
//  each stage holds while its successor is full and stalled; bubbles collapse
`timescale 1ns / 1ps
module zoned_color_ramp_shader #(
  parameter int RATIO_FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  zcrs_in_if.sink                 in_chan,
  zcrs_out_if.source              out_chan,
  input  logic                    cfg_we,
  input  logic [zcrs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [((RATIO_FRAC_BITS+1 > 24) ? RATIO_FRAC_BITS+1 : 24)-1:0] cfg_data
);
  import zcrs_pkg::*;

  localparam int F       = RATIO_FRAC_BITS;
  localparam int RW      = F + 1;
  localparam int AQW     = F + 8;
  localparam int YW      = F + 10;
  localparam int KSH     = F + 10;
  localparam int LW      = F + 10;
  localparam int SW      = 2 + RW;
  localparam int FLOOR_I = ((1 << F) / 1000 > 0) ? (1 << F) / 1000 : 1;
  localparam logic [RW-1:0]  ONE       = RW'(1) << F;
  localparam logic [RW-1:0]  NUM_FLOOR = RW'(FLOOR_I);
  localparam logic [KSH-1:0] RECIP3    = KSH'(((64'd1 << KSH) / 3));

  function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
                                       input logic [RW-1:0] w);
    logic signed [8:0]    diff;
    logic signed [LW-1:0] dx;
    logic signed [LW-1:0] wx;
    logic signed [LW-1:0] s;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    dx   = LW'(diff);
    wx   = $signed({{(LW-RW){1'b0}}, w});
    s    = $signed({{(LW-8-F){1'b0}}, a, {F{1'b0}}}) + dx * wx;
    return s[F+7:F];
  endfunction

  // configuration registers
  logic [RW-1:0]      inner_edge_r, mid_edge_r, smoke_mix_r;
  logic [COLOR_W-1:0] inner_color_r, mid_color_r, outer_color_r;
  logic [GAIN_W-1:0]  opacity_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_edge_r   <= RW'(16384);
      mid_edge_r     <= RW'(36045);
      inner_color_r  <= 24'hFFFFFF;
      mid_color_r    <= 24'hFFA500;
      outer_color_r  <= 24'hFF0000;
      opacity_gain_r <= 10'd256;
      smoke_mix_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INNER_EDGE:   inner_edge_r   <= cfg_data[RW-1:0];
        REG_MID_EDGE:     mid_edge_r     <= cfg_data[RW-1:0];
        REG_INNER_COLOR:  inner_color_r  <= cfg_data[COLOR_W-1:0];
        REG_MID_COLOR:    mid_color_r    <= cfg_data[COLOR_W-1:0];
        REG_OUTER_COLOR:  outer_color_r  <= cfg_data[COLOR_W-1:0];
        REG_OPACITY_GAIN: opacity_gain_r <= cfg_data[GAIN_W-1:0];
        REG_SMOKE_MIX:    smoke_mix_r    <= cfg_data[RW-1:0];
        default: ;
      endcase
    end
  end

  // zone select and divider operands
  logic [RW-1:0] d, life, num, span, den;
  zone_t         zone;
  logic          sat;

  assign d    = in_chan.distance_ratio;
  assign life = in_chan.life_ratio;

  always_comb begin
    if (d < inner_edge_r) begin
      zone = ZONE_INNER;
      num  = d;
      span = inner_edge_r;
    end else if (d < mid_edge_r) begin
      zone = ZONE_MID;
      num  = d - inner_edge_r;
      span = mid_edge_r - inner_edge_r;
    end else begin
      zone = ZONE_OUTER;
      num  = d - mid_edge_r;
      span = (mid_edge_r < ONE) ? ONE - mid_edge_r : '0;
    end
    den = (span > NUM_FLOOR) ? span : NUM_FLOOR;
    sat = num >= den;
  end

  logic          div_out_valid, div_out_sat;
  logic [F-1:0]  div_quot;
  logic [SW-1:0] div_side;
  logic [9:1]    en;
  logic [8:1]    v_r;

  zcrs_div #(.W(RW), .QB(F), .SW(SW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .num       (num),
    .den       (den),
    .sat       (sat),
    .side      ({zone, life}),
    .out_valid (div_out_valid),
    .out_ready (en[1]),
    .quot      (div_quot),
    .out_sat   (div_out_sat),
    .out_side  (div_side)
  );

  always_comb begin
    en[9] = out_chan.ready;
    for (int i = 8; i >= 1; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) v_r[1] <= div_out_valid;
      for (int i = 2; i <= 8; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // stage 1: color blend and base alpha
  logic [RW-1:0]      t;
  zone_t              s1_zone;
  logic [RW-1:0]      s1_life;
  logic [COLOR_W-1:0] ca, cb;
  logic [AQW-1:0]     aq_nxt;
  logic [RW+3:0]      life10;

  assign t       = div_out_sat ? ONE : {1'b0, div_quot};
  assign s1_zone = zone_t'(div_side[SW-1:RW]);
  assign s1_life = div_side[RW-1:0];
  assign life10  = (RW+4)'(s1_life) * (RW+4)'(10);

  always_comb begin
    case (s1_zone)
      ZONE_INNER: begin
        ca     = inner_color_r;
        cb     = mid_color_r;
        aq_nxt = (AQW'(220) << F) - AQW'(t) * AQW'(20);
      end
      ZONE_MID: begin
        ca     = mid_color_r;
        cb     = outer_color_r;
        aq_nxt = (AQW'(200) << F) - AQW'(t) * AQW'(60);
      end
      default: begin
        ca     = outer_color_r;
        cb     = outer_color_r;
        aq_nxt = (AQW'(140) << F) - AQW'(t) * AQW'(140);
      end
    endcase
  end

  logic [7:0]     r1_r, g1_r, b1_r;
  logic [AQW-1:0] aq1_r;
  logic [RW-1:0]  life1_r;
  logic           fade1_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      r1_r    <= lerp8(ca[23:16], cb[23:16], t);
      g1_r    <= lerp8(ca[15:8], cb[15:8], t);
      b1_r    <= lerp8(ca[7:0], cb[7:0], t);
      aq1_r   <= aq_nxt;
      life1_r <= s1_life;
      fade1_r <= life10 < (RW+4)'(3) * (RW+4)'(ONE);
    end
  end

  // stage 2: alpha times life when fading, else zero
  logic [7:0]        r2_r, g2_r, b2_r;
  logic [AQW-1:0]    aq2_r;
  logic [RW-1:0]     life2_r;
  logic              fade2_r;
  logic [AQW+RW-1:0] m2_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      r2_r    <= r1_r;
      g2_r    <= g1_r;
      b2_r    <= b1_r;
      aq2_r   <= aq1_r;
      life2_r <= life1_r;
      fade2_r <= fade1_r;
      m2_r    <= fade1_r ? (AQW+RW)'(aq1_r) * (AQW+RW)'(life1_r) : '0;
    end
  end

  // stage 3: times ten, drop fraction
  logic [AQW+RW+3:0] m10;
  logic [7:0]        r3_r, g3_r, b3_r;
  logic [AQW-1:0]    aq3_r;
  logic [RW-1:0]     life3_r;
  logic              fade3_r;
  logic [YW-1:0]     y3_r;

  assign m10 = ((AQW+RW+4)'(m2_r) << 3) + ((AQW+RW+4)'(m2_r) << 1);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      r3_r    <= r2_r;
      g3_r    <= g2_r;
      b3_r    <= b2_r;
      aq3_r   <= aq2_r;
      life3_r <= life2_r;
      fade3_r <= fade2_r;
      y3_r    <= YW'(m10 >> F);
    end
  end

  // stage 4: divide by three, reciprocal estimate
  logic [YW+KSH-1:0] qprod;
  logic [7:0]        r4_r, g4_r, b4_r;
  logic [AQW-1:0]    aq4_r;
  logic [RW-1:0]     life4_r;
  logic              fade4_r;
  logic [YW-1:0]     y4_r, q4_r;

  assign qprod = (YW+KSH)'(y3_r) * (YW+KSH)'(RECIP3);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      r4_r    <= r3_r;
      g4_r    <= g3_r;
      b4_r    <= b3_r;
      aq4_r   <= aq3_r;
      life4_r <= life3_r;
      fade4_r <= fade3_r;
      y4_r    <= y3_r;
      q4_r    <= YW'(qprod >> KSH);
    end
  end

  // stage 5: quotient correction, faded alpha
  logic [YW-1:0]  qrem, qfix;
  logic [7:0]     r5_r, g5_r, b5_r;
  logic [AQW-1:0] aqf5_r;
  logic [RW-1:0]  life5_r;

  assign qrem = y4_r - q4_r * YW'(3);
  assign qfix = q4_r + ((qrem >= YW'(3)) ? YW'(1) : YW'(0));

  always_ff @(posedge clk) begin
    if (en[5]) begin
      r5_r    <= r4_r;
      g5_r    <= g4_r;
      b5_r    <= b4_r;
      life5_r <= life4_r;
      aqf5_r  <= fade4_r ? qfix[AQW-1:0] : aq4_r;
    end
  end

  // stage 6: opacity gain
  logic [7:0]            r6_r, g6_r, b6_r;
  logic [RW-1:0]         life6_r;
  logic [AQW+GAIN_W-1:0] pa6_r;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      r6_r    <= r5_r;
      g6_r    <= g5_r;
      b6_r    <= b5_r;
      life6_r <= life5_r;
      pa6_r   <= (AQW+GAIN_W)'(aqf5_r) * (AQW+GAIN_W)'(opacity_gain_r);
    end
  end

  // stage 7: alpha clamp, smoke targets
  logic [GAIN_W-1:0] a_raw;
  logic [RW+6:0]     gray_p, sa_p;
  logic [7:0]        r7_r, g7_r, b7_r, a7_r, gray7_r, sa7_r;

  assign a_raw  = GAIN_W'(pa6_r >> (F + 8));
  assign gray_p = (RW+7)'(life6_r) * (RW+7)'(60);
  assign sa_p   = (RW+7)'(life6_r) * (RW+7)'(120);

  always_ff @(posedge clk) begin
    if (en[7]) begin
      r7_r    <= r6_r;
      g7_r    <= g6_r;
      b7_r    <= b6_r;
      a7_r    <= (a_raw > GAIN_W'(255)) ? 8'd255 : a_raw[7:0];
      gray7_r <= 8'd40 + 8'(gray_p >> F);
      sa7_r   <= 8'(sa_p >> F);
    end
  end

  // stage 8: smoke blend into output register
  logic [RW-1:0] mix_w;
  logic          smoke_on;

  assign smoke_on = smoke_mix_r != '0;
  assign mix_w    = (smoke_mix_r > ONE) ? ONE : smoke_mix_r;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      out_chan.red   <= smoke_on ? lerp8(r7_r, gray7_r, mix_w) : r7_r;
      out_chan.green <= smoke_on ? lerp8(g7_r, gray7_r, mix_w) : g7_r;
      out_chan.blue  <= smoke_on ? lerp8(b7_r, gray7_r, mix_w) : b7_r;
      out_chan.alpha <= smoke_on ? lerp8(a7_r, sa7_r, mix_w) : a7_r;
    end
  end

  assign out_chan.valid = v_r[8];

endmodule
